// ----- rtl/sbps_pkg.sv -----
`default_nettype none

package sbps_pkg;

   // Default geometry of the library.
   localparam int LIBRARY_DEPTH_DEFAULT = 1024;
   localparam int PATCH_VALUES_DEFAULT  = 192;

   // Field widths of the channels.
   localparam int REQ_TYPE_W = 2;
   localparam int ENTRY_W    = 10;
   localparam int POSITION_W = 9;
   localparam int VALUE_W    = 8;
   localparam int KIND_W     = 2;
   localparam int ID_W       = 16;
   localparam int SLOT_W     = 2;
   localparam int SCORE_W    = 20;
   localparam int COUNT_W    = 11;

   // Request codes.
   localparam logic [REQ_TYPE_W-1:0] REQ_LIB_VALUE  = 2'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_LIB_HEADER = 2'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_TGT_VALUE  = 2'd2;
   localparam logic [REQ_TYPE_W-1:0] REQ_SEARCH     = 2'd3;

   // Patch shapes.
   localparam logic [KIND_W-1:0] KIND_SQUARE    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_LANDSCAPE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_PORTRAIT  = 2'd2;

   // Target slots.
   localparam logic [SLOT_W-1:0] SLOT_OWN   = 2'd0;
   localparam logic [SLOT_W-1:0] SLOT_SIDE  = 2'd1;
   localparam logic [SLOT_W-1:0] SLOT_BELOW = 2'd2;
   localparam int               SLOT_COUNT = 3;

   // Scoring constants.
   localparam int SCORE_LIMIT   = 1000000;
   localparam int SIDE_PENALTY  = 100000;
   localparam int BELOW_PENALTY = 10000000;

endpackage

`default_nettype wire

// ----- rtl/sbps_req_if.sv -----
`default_nettype none

interface sbps_req_if;
   logic                                valid;
   logic                                ready;
   logic [sbps_pkg::REQ_TYPE_W-1:0]     req_type;
   logic [sbps_pkg::ENTRY_W-1:0]        entry;
   logic [sbps_pkg::POSITION_W-1:0]     position;
   logic [sbps_pkg::VALUE_W-1:0]        value;
   logic [sbps_pkg::KIND_W-1:0]         kind;
   logic [sbps_pkg::ID_W-1:0]           patch_id;
   logic [sbps_pkg::SLOT_W-1:0]         target_slot;
   logic                                side_valid;
   logic                                below_valid;

   modport source (
      output valid, req_type, entry, position, value, kind, patch_id, target_slot,
             side_valid, below_valid,
      input  ready
   );

   modport sink (
      input  valid, req_type, entry, position, value, kind, patch_id, target_slot,
             side_valid, below_valid,
      output ready
   );
endinterface

`default_nettype wire

// ----- rtl/sbps_rsp_if.sv -----
`default_nettype none

interface sbps_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [sbps_pkg::ID_W-1:0]       best_id;
   logic [sbps_pkg::SCORE_W-1:0]    match_score;
   logic                            found;

   modport source (
      output valid, best_id, match_score, found,
      input  ready
   );

   modport sink (
      input  valid, best_id, match_score, found,
      output ready
   );
endinterface

`default_nettype wire

// ----- rtl/sbps_csr_if.sv -----
`default_nettype none

interface sbps_csr_if;
   logic                            valid;
   logic                            ready;
   logic [sbps_pkg::COUNT_W-1:0]    library_count;

   modport source (
      output valid, library_count,
      input  ready
   );

   modport sink (
      input  valid, library_count,
      output ready
   );
endinterface

`default_nettype wire

// ----- rtl/sad_best_patch_search.sv -----
// Best patch search by sum of absolute differences.
// The req_chan channel carries one request per handshake: a library value load,
// a library header load (shape and id), a target value load, or a search. Loads
// are written into on-chip memories in the cycle they are accepted and return
// nothing. A search scores every loaded entry against the stored target and
// returns exactly one response on rsp_chan with the winning id and score.
// The csr_chan port writes library_count, the number of entries a search visits;
// it is always ready and should be written only while no search is running.
// A search walks each entry through one shared absolute difference and accumulate
// unit, one value per cycle, fed by a single read port of the value memory.
// Square entries and entries whose neighbor is missing are summed over one half,
// two-half shapes with a present neighbor over both, and unknown shapes skipped.
// req_chan.ready is low for the whole search. Results sit in an output register,
// so loads are accepted while a response waits; a stalled receiver only holds a
// finished search in its last state until the register frees up. Reset clears the
// sequencer, the pending response and library_count; memory contents are
// undefined until written.

`default_nettype none

module sad_best_patch_search #(
   parameter int LIBRARY_DEPTH = sbps_pkg::LIBRARY_DEPTH_DEFAULT,
   parameter int PATCH_VALUES  = sbps_pkg::PATCH_VALUES_DEFAULT
) (
   input  wire         clock,
   input  wire         reset,
   sbps_req_if.sink    req_chan,
   sbps_rsp_if.source  rsp_chan,
   sbps_csr_if.sink    csr_chan
);

   // Derived geometry.
   localparam int ENTRY_VALUES = 2 * PATCH_VALUES;
   localparam int LIB_WORDS    = LIBRARY_DEPTH * ENTRY_VALUES;
   localparam int TGT_WORDS    = sbps_pkg::SLOT_COUNT * PATCH_VALUES;
   localparam int LIB_AW       = (LIB_WORDS > 1) ? $clog2(LIB_WORDS) : 1;
   localparam int TGT_AW       = (TGT_WORDS > 1) ? $clog2(TGT_WORDS) : 1;
   localparam int ENTRY_AW     = (LIBRARY_DEPTH > 1) ? $clog2(LIBRARY_DEPTH) : 1;
   localparam int CNT_W        = $clog2(LIBRARY_DEPTH + 1);
   localparam int K_W          = (PATCH_VALUES > 1) ? $clog2(PATCH_VALUES) : 1;
   localparam int ACC_MAX      = ENTRY_VALUES * 255 + sbps_pkg::BELOW_PENALTY;
   localparam int ACC_W        = $clog2(ACC_MAX + 1);
   localparam int HDR_W        = sbps_pkg::KIND_W + sbps_pkg::ID_W;

   // Sequencer states.
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_HDR   = 3'd1;
   localparam logic [2:0] S_KIND  = 3'd2;
   localparam logic [2:0] S_SUM   = 3'd3;
   localparam logic [2:0] S_DRAIN = 3'd4;
   localparam logic [2:0] S_EVAL  = 3'd5;
   localparam logic [2:0] S_CMP   = 3'd6;
   localparam logic [2:0] S_DONE  = 3'd7;

   // Memories.
   logic [sbps_pkg::VALUE_W-1:0] lib_mem [LIB_WORDS];
   logic [HDR_W-1:0]             hdr_mem [LIBRARY_DEPTH];
   logic [sbps_pkg::VALUE_W-1:0] tgt_mem [TGT_WORDS];

   logic [sbps_pkg::VALUE_W-1:0] lib_rd_ff;
   logic [sbps_pkg::VALUE_W-1:0] tgt_rd_ff;
   logic [HDR_W-1:0]             hdr_rd_ff;

   // Control registers.
   logic [2:0]                   state_ff, state_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rd_valid_ff, rd_valid_in;
   logic [sbps_pkg::COUNT_W-1:0] lib_count_ff, lib_count_in;

   // Datapath registers.
   logic [CNT_W-1:0]             e_ff, e_in;
   logic [CNT_W-1:0]             count_ff, count_in;
   logic [LIB_AW-1:0]            base_ff, base_in;
   logic [LIB_AW-1:0]            ptr_ff, ptr_in;
   logic [TGT_AW-1:0]            tgt_ptr_ff, tgt_ptr_in;
   logic [K_W-1:0]               k_ff, k_in;
   logic                         half_ff, half_in;
   logic                         halve_ff, halve_in;
   logic [ACC_W-1:0]             acc_ff, acc_in;
   logic [sbps_pkg::SCORE_W-1:0] best_ff, best_in;
   logic [sbps_pkg::ID_W-1:0]    best_id_ff, best_id_in;
   logic                         found_ff, found_in;
   logic                         side_ff, side_in;
   logic                         below_ff, below_in;
   logic [sbps_pkg::ID_W-1:0]    rsp_id_ff, rsp_id_in;
   logic [sbps_pkg::SCORE_W-1:0] rsp_score_ff, rsp_score_in;
   logic                         rsp_found_ff, rsp_found_in;

   // Request decode.
   logic                         req_fire;
   logic                         lib_we;
   logic                         hdr_we;
   logic                         tgt_we;
   logic [LIB_AW-1:0]            lib_wr_addr;
   logic [TGT_AW-1:0]            tgt_wr_addr;
   logic [CNT_W-1:0]             count_clip;

   // Shared arithmetic.
   logic [sbps_pkg::VALUE_W-1:0] abs_diff;
   logic [ACC_W-1:0]             addend;
   logic [ACC_W-1:0]             acc_sum;
   logic                         penalty_add;
   logic                         advance;
   logic [CNT_W-1:0]             e_next;
   logic [ACC_W-1:0]             score;
   logic [sbps_pkg::KIND_W-1:0]  hdr_kind;
   logic [sbps_pkg::ID_W-1:0]    hdr_id;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign csr_chan.ready = 1'b1;
   assign req_fire       = req_chan.valid && req_chan.ready;

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.best_id     = rsp_id_ff;
   assign rsp_chan.match_score = rsp_score_ff;
   assign rsp_chan.found       = rsp_found_ff;

   // Loads outside the stored ranges are dropped.
   assign lib_we = req_fire && (req_chan.req_type == sbps_pkg::REQ_LIB_VALUE)
                   && (32'(req_chan.entry) < 32'(LIBRARY_DEPTH))
                   && (32'(req_chan.position) < 32'(ENTRY_VALUES));
   assign hdr_we = req_fire && (req_chan.req_type == sbps_pkg::REQ_LIB_HEADER)
                   && (32'(req_chan.entry) < 32'(LIBRARY_DEPTH));
   assign tgt_we = req_fire && (req_chan.req_type == sbps_pkg::REQ_TGT_VALUE)
                   && (32'(req_chan.target_slot) < 32'(sbps_pkg::SLOT_COUNT))
                   && (32'(req_chan.position) < 32'(PATCH_VALUES));

   assign lib_wr_addr = LIB_AW'(32'(req_chan.entry) * ENTRY_VALUES
                                + 32'(req_chan.position));
   assign tgt_wr_addr = TGT_AW'(32'(req_chan.target_slot) * PATCH_VALUES
                                + 32'(req_chan.position));

   // A count above the library depth searches the whole library.
   assign count_clip = (32'(lib_count_ff) > 32'(LIBRARY_DEPTH)) ?
                       CNT_W'(LIBRARY_DEPTH) : CNT_W'(lib_count_ff);

   assign hdr_kind = hdr_rd_ff[HDR_W-1 -: sbps_pkg::KIND_W];
   assign hdr_id   = hdr_rd_ff[sbps_pkg::ID_W-1:0];

   assign abs_diff = (lib_rd_ff > tgt_rd_ff) ? (lib_rd_ff - tgt_rd_ff)
                                             : (tgt_rd_ff - lib_rd_ff);
   assign addend   = penalty_add ?
                     ((hdr_kind == sbps_pkg::KIND_LANDSCAPE) ?
                      ACC_W'(sbps_pkg::SIDE_PENALTY) : ACC_W'(sbps_pkg::BELOW_PENALTY)) :
                     ACC_W'(abs_diff);
   assign acc_sum  = acc_ff + addend;
   assign score    = halve_ff ? (acc_ff >> 1) : acc_ff;
   assign e_next   = e_ff + CNT_W'(1);

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rd_valid_in  = 1'b0;
      lib_count_in = lib_count_ff;
      e_in         = e_ff;
      count_in     = count_ff;
      base_in      = base_ff;
      ptr_in       = ptr_ff;
      tgt_ptr_in   = tgt_ptr_ff;
      k_in         = k_ff;
      half_in      = half_ff;
      halve_in     = halve_ff;
      acc_in       = acc_ff;
      best_in      = best_ff;
      best_id_in   = best_id_ff;
      found_in     = found_ff;
      side_in      = side_ff;
      below_in     = below_ff;
      rsp_id_in    = rsp_id_ff;
      rsp_score_in = rsp_score_ff;
      rsp_found_in = rsp_found_ff;
      penalty_add  = 1'b0;
      advance      = 1'b0;

      if (csr_chan.valid) begin
         lib_count_in = csr_chan.library_count;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire && (req_chan.req_type == sbps_pkg::REQ_SEARCH)) begin
               side_in  = req_chan.side_valid;
               below_in = req_chan.below_valid;
               count_in = count_clip;
               e_in     = '0;
               base_in  = '0;
               best_in  = sbps_pkg::SCORE_W'(sbps_pkg::SCORE_LIMIT);
               best_id_in = '0;
               found_in = 1'b0;
               state_in = (count_clip == '0) ? S_DONE : S_HDR;
            end
         end
         S_HDR: begin
            state_in = S_KIND;
         end
         S_KIND: begin
            if (hdr_kind > sbps_pkg::KIND_PORTRAIT) begin
               advance = 1'b1;
            end else begin
               ptr_in     = base_ff;
               tgt_ptr_in = '0;
               k_in       = '0;
               half_in    = 1'b0;
               acc_in     = '0;
               state_in   = S_SUM;
            end
         end
         S_SUM: begin
            rd_valid_in = 1'b1;
            ptr_in      = ptr_ff + LIB_AW'(1);
            tgt_ptr_in  = tgt_ptr_ff + TGT_AW'(1);
            k_in        = k_ff + K_W'(1);
            if (k_ff == K_W'(PATCH_VALUES - 1)) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_EVAL;
         end
         S_EVAL: begin
            if (half_ff) begin
               halve_in = 1'b1;
               state_in = S_CMP;
            end else if (hdr_kind == sbps_pkg::KIND_SQUARE) begin
               halve_in = 1'b0;
               state_in = S_CMP;
            end else if ((hdr_kind == sbps_pkg::KIND_LANDSCAPE && side_ff) ||
                         (hdr_kind == sbps_pkg::KIND_PORTRAIT && below_ff)) begin
               // The value pointer already sits on the extension half.
               half_in    = 1'b1;
               k_in       = '0;
               tgt_ptr_in = (hdr_kind == sbps_pkg::KIND_LANDSCAPE) ?
                            TGT_AW'(PATCH_VALUES) : TGT_AW'(2 * PATCH_VALUES);
               state_in   = S_SUM;
            end else begin
               penalty_add = 1'b1;
               halve_in    = 1'b1;
               state_in    = S_CMP;
            end
         end
         S_CMP: begin
            if (32'(score) < 32'(best_ff)) begin
               best_in    = sbps_pkg::SCORE_W'(score);
               best_id_in = hdr_id;
               found_in   = 1'b1;
            end
            advance = 1'b1;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_id_in    = found_ff ? best_id_ff : '0;
               rsp_score_in = found_ff ? best_ff : '0;
               rsp_found_in = found_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // One adder serves both the running sum and the missing-neighbor penalty.
      if (rd_valid_ff || penalty_add) begin
         acc_in = acc_sum;
      end

      if (advance) begin
         e_in     = e_next;
         base_in  = LIB_AW'(32'(base_ff) + ENTRY_VALUES);
         state_in = (e_next == count_ff) ? S_DONE : S_HDR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         rd_valid_ff  <= 1'b0;
         lib_count_ff <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_valid_ff  <= rd_valid_in;
         lib_count_ff <= lib_count_in;
      end
   end

   always_ff @(posedge clock) begin
      e_ff         <= e_in;
      count_ff     <= count_in;
      base_ff      <= base_in;
      ptr_ff       <= ptr_in;
      tgt_ptr_ff   <= tgt_ptr_in;
      k_ff         <= k_in;
      half_ff      <= half_in;
      halve_ff     <= halve_in;
      acc_ff       <= acc_in;
      best_ff      <= best_in;
      best_id_ff   <= best_id_in;
      found_ff     <= found_in;
      side_ff      <= side_in;
      below_ff     <= below_in;
      rsp_id_ff    <= rsp_id_in;
      rsp_score_ff <= rsp_score_in;
      rsp_found_ff <= rsp_found_in;
   end

   // Library value memory: one write port for loads, one read port for the search.
   always_ff @(posedge clock) begin
      if (lib_we) begin
         lib_mem[lib_wr_addr] <= req_chan.value;
      end
      lib_rd_ff <= lib_mem[ptr_ff];
   end

   // Header memory holds shape and id of each entry.
   always_ff @(posedge clock) begin
      if (hdr_we) begin
         hdr_mem[ENTRY_AW'(req_chan.entry)] <= {req_chan.kind, req_chan.patch_id};
      end
      hdr_rd_ff <= hdr_mem[e_ff[ENTRY_AW-1:0]];
   end

   // Target memory holds the own patch and both neighbors back to back.
   always_ff @(posedge clock) begin
      if (tgt_we) begin
         tgt_mem[tgt_wr_addr] <= req_chan.value;
      end
      tgt_rd_ff <= tgt_mem[tgt_ptr_ff];
   end

`ifndef SYNTHESIS
   // A response that found nothing carries a zero id and score.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_found_ff) |-> (rsp_id_ff == '0 && rsp_score_ff == '0))
      else $error("empty response carries a nonzero payload");

   // A reported score always lies below the limit.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_found_ff) |->
         (32'(rsp_score_ff) < 32'(sbps_pkg::SCORE_LIMIT)))
      else $error("reported score is not below the limit");

   // Memory read data is summed only right after a summing cycle.
   assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |-> (state_ff == S_SUM || state_ff == S_DRAIN))
      else $error("accumulate outside of a summing pass");

   // The entry counter stays inside the searched range while an entry is scored.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_HDR || state_ff == S_KIND || state_ff == S_SUM ||
       state_ff == S_EVAL || state_ff == S_CMP) |-> (e_ff < count_ff))
      else $error("entry index beyond the searched count");
`endif

endmodule

`default_nettype wire

// ----- test/sad_best_patch_search_tb.sv -----
`default_nettype none

module sad_best_patch_search_tb;
   import sbps_pkg::*;

   // Geometry of the block under test, taken from the package defaults.
   localparam int LIB_DEPTH = LIBRARY_DEPTH_DEFAULT;
   localparam int HALF      = PATCH_VALUES_DEFAULT;
   localparam int ROW       = 2 * HALF;

   // Codes the package does not name: a shape the search skips and a slot
   // that does not exist.
   localparam logic [KIND_W-1:0] KIND_UNKNOWN = 2'd3;
   localparam logic [SLOT_W-1:0] SLOT_NONE    = 2'd3;

   // The longest quiet stretch is one search over 1024 entries, most of them
   // of unknown shape.
   localparam int QUIET_LIMIT   = 50000;
   localparam int SETTLE_CYCLES = 8;

   typedef struct {
      logic [REQ_TYPE_W-1:0] req_type;
      logic [ENTRY_W-1:0]    entry;
      logic [POSITION_W-1:0] position;
      logic [VALUE_W-1:0]    value;
      logic [KIND_W-1:0]     kind;
      logic [ID_W-1:0]       patch_id;
      logic [SLOT_W-1:0]     target_slot;
      logic                  side_valid;
      logic                  below_valid;
   } patch_request_type;

   typedef struct {
      logic [ID_W-1:0]    best_id;
      logic [SCORE_W-1:0] match_score;
      logic               found;
   } match_result_type;

   // The scoreboard keeps its own copy of the library, the target patches and
   // the entry count. Every accepted request updates that copy, and every
   // accepted search queues the match that the block must return for it.
   class match_scoreboard;
      bit [VALUE_W-1:0] lib_values [LIB_DEPTH][ROW];
      bit [KIND_W-1:0]  lib_kinds [LIB_DEPTH];
      bit [ID_W-1:0]    lib_ids [LIB_DEPTH];
      bit [VALUE_W-1:0] target_values [SLOT_COUNT][HALF];
      int               library_count;
      match_result_type expected_matches[$];
      int               errors;

      function void set_count(logic [COUNT_W-1:0] count);
         library_count = count;
      endfunction

      function int unsigned half_sad(int e, int offset, int slot);
         int unsigned acc;
         int          a;
         int          b;
         acc = 0;
         for (int k = 0; k < HALF; k++) begin
            a = lib_values[e][offset + k];
            b = target_values[slot][k];
            acc += (a > b) ? a - b : b - a;
         end
         return acc;
      endfunction

      function match_result_type best_match(bit side_ok, bit below_ok);
         match_result_type res;
         int unsigned      score;
         int unsigned      best;
         int               span;
         res  = '{default: '0};
         best = SCORE_LIMIT;
         span = (library_count > LIB_DEPTH) ? LIB_DEPTH : library_count;
         for (int e = 0; e < span; e++) begin
            if (lib_kinds[e] == KIND_UNKNOWN) continue;
            score = half_sad(e, 0, SLOT_OWN);
            if (lib_kinds[e] == KIND_LANDSCAPE) begin
               score = (score + (side_ok ? half_sad(e, HALF, SLOT_SIDE) : SIDE_PENALTY)) / 2;
            end else if (lib_kinds[e] == KIND_PORTRAIT) begin
               score = (score + (below_ok ? half_sad(e, HALF, SLOT_BELOW) : BELOW_PENALTY)) / 2;
            end
            // Strictly lower only, so the earlier entry keeps a tie.
            if (score < best) begin
               best            = score;
               res.best_id     = lib_ids[e];
               res.match_score = score[SCORE_W-1:0];
               res.found       = 1'b1;
            end
         end
         return res;
      endfunction

      function void note_request(patch_request_type r);
         case (r.req_type)
            REQ_LIB_VALUE: begin
               if (r.position < ROW) lib_values[r.entry][r.position] = r.value;
            end
            REQ_LIB_HEADER: begin
               lib_kinds[r.entry] = r.kind;
               lib_ids[r.entry]   = r.patch_id;
            end
            REQ_TGT_VALUE: begin
               if (r.target_slot < SLOT_COUNT && r.position < HALF)
                  target_values[r.target_slot][r.position] = r.value;
            end
            default: begin
               expected_matches.insert(expected_matches.size(),
                                       best_match(r.side_valid, r.below_valid));
            end
         endcase
      endfunction

      task report(string what);
         errors++;
         if (errors <= 50) $display("MISMATCH: %s", what);
      endtask

      task check_response(match_result_type got);
         match_result_type want;
         if (expected_matches.size() == 0) begin
            report("response arrived with no search outstanding");
            return;
         end
         want = expected_matches.pop_front();
         if (got.best_id !== want.best_id)
            report($sformatf("best_id got %h, wanted %h", got.best_id, want.best_id));
         if (got.match_score !== want.match_score)
            report($sformatf("match_score got %0d, wanted %0d", got.match_score,
                             want.match_score));
         if (got.found !== want.found)
            report($sformatf("found got %b, wanted %b", got.found, want.found));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset;

   sbps_req_if req_bus ();
   sbps_rsp_if rsp_bus ();
   sbps_csr_if csr_bus ();

   sad_best_patch_search dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   match_scoreboard   sb;
   patch_request_type seen_request;
   match_result_type  seen_match;

   // Knobs of the traffic shape, in percent of cycles.
   int send_idle_pct;
   int stall_pct;
   int idle_plan  [4] = '{0, 69, 0, 38};
   int stall_plan [4] = '{0, 0, 69, 38};

   // The stimulus side remembers which store locations it has loaded, so that
   // a search never reaches a location that was never written. It also keeps
   // the entry count it last programmed.
   bit                value_loaded [LIB_DEPTH][ROW];
   bit                header_loaded [LIB_DEPTH];
   logic [KIND_W-1:0] loaded_kind [LIB_DEPTH];
   bit                target_loaded [SLOT_COUNT][HALF];
   int                library_count_now;
   int                quiet_cycles;

   always #10 clock = ~clock;

   // The monitor samples at the rising edge, before any driver update of the
   // same edge takes effect, so it sees exactly what the block saw.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            seen_request.req_type    = req_bus.req_type;
            seen_request.entry       = req_bus.entry;
            seen_request.position    = req_bus.position;
            seen_request.value       = req_bus.value;
            seen_request.kind        = req_bus.kind;
            seen_request.patch_id    = req_bus.patch_id;
            seen_request.target_slot = req_bus.target_slot;
            seen_request.side_valid  = req_bus.side_valid;
            seen_request.below_valid = req_bus.below_valid;
            sb.note_request(seen_request);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            seen_match.best_id     = rsp_bus.best_id;
            seen_match.match_score = rsp_bus.match_score;
            seen_match.found       = rsp_bus.found;
            sb.check_response(seen_match);
         end
         if (csr_bus.valid && csr_bus.ready) sb.set_count(csr_bus.library_count);
      end
   end

   // The receiver stalls at random, at the rate of the current phase.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // The watchdog ends a run in which no channel has moved for too long.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (csr_bus.valid && csr_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Every request starts as random noise, so that the fields a request type
   // does not use still toggle; the builders then set the fields that matter.
   function automatic patch_request_type noise_request();
      patch_request_type r;
      r.req_type    = REQ_TYPE_W'($urandom);
      r.entry       = ENTRY_W'($urandom);
      r.position    = POSITION_W'($urandom);
      r.value       = VALUE_W'($urandom);
      r.kind        = KIND_W'($urandom);
      r.patch_id    = ID_W'($urandom);
      r.target_slot = SLOT_W'($urandom);
      r.side_valid  = 1'($urandom);
      r.below_valid = 1'($urandom);
      return r;
   endfunction

   function automatic patch_request_type value_request(int entry, int pos, int val);
      patch_request_type r;
      r          = noise_request();
      r.req_type = REQ_LIB_VALUE;
      r.entry    = ENTRY_W'(entry);
      r.position = POSITION_W'(pos);
      r.value    = VALUE_W'(val);
      return r;
   endfunction

   function automatic patch_request_type header_request(int entry, int kind, int id);
      patch_request_type r;
      r          = noise_request();
      r.req_type = REQ_LIB_HEADER;
      r.entry    = ENTRY_W'(entry);
      r.kind     = KIND_W'(kind);
      r.patch_id = ID_W'(id);
      return r;
   endfunction

   function automatic patch_request_type target_request(int slot, int pos, int val);
      patch_request_type r;
      r             = noise_request();
      r.req_type    = REQ_TGT_VALUE;
      r.target_slot = SLOT_W'(slot);
      r.position    = POSITION_W'(pos);
      r.value       = VALUE_W'(val);
      return r;
   endfunction

   // Hands one request to the block and waits for its handshake. Valid stays
   // high into the next request unless the sender decides to idle.
   task automatic issue_request(patch_request_type r);
      case (r.req_type)
         REQ_LIB_VALUE: begin
            if (r.position < ROW) value_loaded[r.entry][r.position] = 1'b1;
         end
         REQ_LIB_HEADER: begin
            header_loaded[r.entry] = 1'b1;
            loaded_kind[r.entry]   = r.kind;
         end
         REQ_TGT_VALUE: begin
            if (r.target_slot < SLOT_COUNT && r.position < HALF)
               target_loaded[r.target_slot][r.position] = 1'b1;
         end
         default: begin
         end
      endcase
      req_bus.valid       <= 1'b1;
      req_bus.req_type    <= r.req_type;
      req_bus.entry       <= r.entry;
      req_bus.position    <= r.position;
      req_bus.value       <= r.value;
      req_bus.kind        <= r.kind;
      req_bus.patch_id    <= r.patch_id;
      req_bus.target_slot <= r.target_slot;
      req_bus.side_valid  <= r.side_valid;
      req_bus.below_valid <= r.below_valid;
      do @(posedge clock); while (!req_bus.ready);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   // Loads whatever part of one library half and one target slot is still
   // unwritten.
   task automatic fill_half(int e, int offset, int slot);
      for (int p = 0; p < HALF; p++) begin
         if (!value_loaded[e][offset + p])
            issue_request(value_request(e, offset + p, $urandom_range(255)));
         if (!target_loaded[slot][p])
            issue_request(target_request(slot, p, $urandom_range(255)));
      end
   endtask

   // Before a search, every location it is going to read gets loaded. Fresh
   // headers near the start of the library get a random shape; those further
   // out get the unknown shape, which keeps the long searches short.
   task automatic run_search(bit side_ok, bit below_ok);
      int                span;
      patch_request_type r;
      span = (library_count_now > LIB_DEPTH) ? LIB_DEPTH : library_count_now;
      for (int e = 0; e < span; e++) begin
         if (!header_loaded[e])
            issue_request(header_request(e, (e < 8) ? $urandom_range(3) : KIND_UNKNOWN,
                                         $urandom));
         if (loaded_kind[e] != KIND_UNKNOWN) fill_half(e, 0, SLOT_OWN);
         if (loaded_kind[e] == KIND_LANDSCAPE && side_ok) fill_half(e, HALF, SLOT_SIDE);
         if (loaded_kind[e] == KIND_PORTRAIT && below_ok) fill_half(e, HALF, SLOT_BELOW);
      end
      r             = noise_request();
      r.req_type    = REQ_SEARCH;
      r.side_valid  = side_ok;
      r.below_valid = below_ok;
      issue_request(r);
   endtask

   // Holds off the sender until every search has answered, then lets the
   // block settle.
   task automatic settle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (sb.expected_matches.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Only called while the block is idle.
   task automatic write_library_count(int count);
      csr_bus.library_count <= COUNT_W'(count);
      csr_bus.valid         <= 1'b1;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      library_count_now = count;
   endtask

   // One random request. Loads lean towards the first few entries, which are
   // the ones the searches visit; a tenth of value loads and more target loads are out of range.
   task automatic random_item();
      int pick;
      int entry;
      pick  = $urandom_range(99);
      entry = ($urandom_range(9) < 8) ? $urandom_range(7) : $urandom_range(LIB_DEPTH - 1);
      if (pick < 35) begin
         issue_request(value_request(entry, ($urandom_range(9) == 0) ?
                       $urandom_range(ROW, 511) : $urandom_range(ROW - 1), $urandom_range(255)));
      end else if (pick < 45) begin
         issue_request(header_request(entry, $urandom_range(3), $urandom));
      end else if (pick < 65) begin
         issue_request(target_request(($urandom_range(15) == 0) ? SLOT_NONE :
                       $urandom_range(SLOT_COUNT - 1), ($urandom_range(9) == 0) ?
                       $urandom_range(HALF, 511) : $urandom_range(HALF - 1),
                       $urandom_range(255)));
      end else begin
         run_search(1'($urandom), 1'($urandom));
      end
   endtask

   initial begin
      sb = new();
      send_idle_pct     = 0;
      stall_pct         = 0;
      library_count_now = 0;
      reset                 <= 1'b1;
      req_bus.valid         <= 1'b0;
      req_bus.req_type      <= '0;
      req_bus.entry         <= '0;
      req_bus.position      <= '0;
      req_bus.value         <= '0;
      req_bus.kind          <= '0;
      req_bus.patch_id      <= '0;
      req_bus.target_slot   <= '0;
      req_bus.side_valid    <= 1'b0;
      req_bus.below_valid   <= 1'b0;
      csr_bus.valid         <= 1'b0;
      csr_bus.library_count <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // The entry count is zero after reset, so nothing can be found.
      run_search(1'b1, 1'b1);

      // Two entries: a square one and a landscape one, with and without the
      // side neighbour, which brings in the side penalty.
      settle();
      write_library_count(2);
      issue_request(header_request(0, KIND_SQUARE, 16'hFFFF));
      issue_request(header_request(1, KIND_LANDSCAPE, 16'h0000));
      run_search(1'b1, 1'b1);
      run_search(1'b0, 1'b1);

      // The second entry turns portrait. Without the below neighbour its score
      // is far above the limit, so it can never win.
      issue_request(header_request(1, KIND_PORTRAIT, 16'h8001));
      run_search(1'b1, 1'b1);
      run_search(1'b1, 1'b0);

      // A tie at the largest possible distance: both first halves all zero,
      // the target all 255. The earlier entry has to win.
      for (int p = 0; p < HALF; p++) begin
         issue_request(value_request(0, p, 0));
         issue_request(value_request(1, p, 0));
         issue_request(target_request(SLOT_OWN, p, 255));
      end
      issue_request(header_request(1, KIND_SQUARE, 16'h7FFE));
      run_search(1'b0, 1'b0);

      // An entry of unknown shape is skipped, so the second entry wins alone.
      issue_request(header_request(0, KIND_UNKNOWN, 16'h1234));
      run_search(1'b0, 1'b0);

      // Loads outside the stores must be dropped; the next search would show
      // any of them landing on a real location.
      issue_request(value_request(1, ROW, 8'hAA));
      issue_request(value_request(1, 511, 8'h55));
      issue_request(target_request(SLOT_OWN, HALF, 0));
      issue_request(target_request(SLOT_NONE, 0, 0));
      issue_request(target_request(SLOT_BELOW, 511, 8'h0F));
      run_search(1'b0, 1'b0);

      // The last entry of the library, then searches over the whole library:
      // once at exactly its depth and once with a count beyond it.
      issue_request(header_request(LIB_DEPTH - 1, KIND_LANDSCAPE, $urandom));
      issue_request(value_request(LIB_DEPTH - 1, ROW - 1, 255));
      settle();
      write_library_count(LIB_DEPTH);
      run_search(1'b1, 1'b1);
      settle();
      write_library_count((1 << COUNT_W) - 1);
      run_search(1'b1, 1'b0);

      // Random traffic in four phases of idling and stalling, each with a pause and a new
      // entry count halfway through.
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = idle_plan[ph];
         stall_pct     = stall_plan[ph];
         settle();
         write_library_count($urandom_range(1, 6));
         repeat (12) random_item();
         settle();
         write_library_count($urandom_range(0, 6));
         repeat (13) random_item();
      end

      settle();
      if (sb.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

`default_nettype wire
